/* rtl/core/lsrc_pkg.sv */
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: shared package
// Field widths, register indexes, fail codes and the rectangle record.
// ----------------------------------------------------------------------------
package lsrc_pkg;

	localparam int COORD_W        = 16;
	localparam int RECT_W         = 12;
	localparam int REASON_W       = 3;
	localparam int CFG_IDX_W      = 4;
	localparam int DEF_MAX_POINTS = 128;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECT_LEFT   = 4'd0,
		CFG_RECT_TOP    = 4'd1,
		CFG_RECT_WIDTH  = 4'd2,
		CFG_RECT_HEIGHT = 4'd3
	} cfg_idx_t;

	// verdict codes, first failing test wins
	typedef enum logic [REASON_W-1:0] {
		REASON_PASS   = 3'd0,
		REASON_SPAN_X = 3'd1,
		REASON_SPAN_Y = 3'd2,
		REASON_CTR_X  = 3'd3,
		REASON_CTR_Y  = 3'd4
	} reason_t;

	typedef struct packed {
		logic [RECT_W-1:0] left;
		logic [RECT_W-1:0] top;
		logic [RECT_W-1:0] width;
		logic [RECT_W-1:0] height;
	} rect_t;

endpackage

/* rtl/core/lsrc_channels.sv */
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: channel interfaces
// Point input, verdict output and register write channels.
// ----------------------------------------------------------------------------
interface lsrc_point_if;
	logic                        valid;
	logic                        ready;
	logic [lsrc_pkg::COORD_W-1:0] point_x;
	logic [lsrc_pkg::COORD_W-1:0] point_y;
	logic                        last_point;

	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lsrc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         inside_res;
	logic [lsrc_pkg::REASON_W-1:0] fail_reason;

	modport source (output valid, inside_res, fail_reason, input ready);
	modport sink   (input valid, inside_res, fail_reason, output ready);
endinterface

interface lsrc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lsrc_pkg::CFG_IDX_W-1:0] reg_index;
	logic [lsrc_pkg::RECT_W-1:0]    wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/core/landmark_shape_in_rect_check.sv */
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: top level
// Accumulates landmark points and gives one fit verdict per shape.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                           transaction
//  --------  ---  --------------------------------  ------------------------
//  points    in   point_x, point_y, last_point      one landmark point
//  verdict   out  inside_res, fail_reason           one verdict per shape
//  cfg       in   reg_index, wr_data                one register write
//
//  One point can be taken every cycle. A non-last point never waits in the
//  input register; a last point waits there while the snapshot is occupied,
//  and the points behind it wait with it.
//  A verdict passes from its last point through the input register, the
//  snapshot, the products and the comparisons into the result register. The
//  pipeline stages only stall when the verdict side backs up into them.
//  Reset clears the accumulators and sets the rectangle to left 0, top 0,
//  width 1, height 1. Register writes are always taken; write only while idle.
//
module landmark_shape_in_rect_check #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS
) (
	input  logic          clk,
	input  logic          arst_n,
	lsrc_point_if.sink    points,
	lsrc_result_if.source verdict,
	lsrc_cfg_if.sink      cfg
);

	localparam int N_W = $clog2(MAX_POINTS + 1);
	localparam int T_W = $clog2(MAX_POINTS * ((1 << lsrc_pkg::COORD_W) - 1) + 1);

	lsrc_pkg::rect_t rect_q;

	logic                         job_valid;
	logic                         job_ready;
	logic [lsrc_pkg::COORD_W-1:0] job_span_x;
	logic [lsrc_pkg::COORD_W-1:0] job_span_y;
	logic [T_W-1:0]               job_total_x;
	logic [T_W-1:0]               job_total_y;
	logic [N_W-1:0]               job_count;

	// register writes need no back-pressure
	assign cfg.ready = 1'b1;

	// hold the rectangle; drop writes to indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q.left   <= '0;
			rect_q.top    <= '0;
			rect_q.width  <= lsrc_pkg::RECT_W'(1);
			rect_q.height <= lsrc_pkg::RECT_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				lsrc_pkg::CFG_RECT_LEFT:   rect_q.left   <= cfg.wr_data;
				lsrc_pkg::CFG_RECT_TOP:    rect_q.top    <= cfg.wr_data;
				lsrc_pkg::CFG_RECT_WIDTH:  rect_q.width  <= cfg.wr_data;
				lsrc_pkg::CFG_RECT_HEIGHT: rect_q.height <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// min, max, sum and count; snapshot handed on at each last point
	lsrc_accum #(
		.MAX_POINTS(MAX_POINTS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.points      (points),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job_span_x  (job_span_x),
		.job_span_y  (job_span_y),
		.job_total_x (job_total_x),
		.job_total_y (job_total_y),
		.job_count   (job_count)
	);

	// cross-multiplied span and centre tests, first failure reported
	lsrc_verdict #(
		.MAX_POINTS(MAX_POINTS)
	) u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.rect        (rect_q),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job_span_x  (job_span_x),
		.job_span_y  (job_span_y),
		.job_total_x (job_total_x),
		.job_total_y (job_total_y),
		.job_count   (job_count),
		.verdict     (verdict)
	);

endmodule

/* rtl/core/lsrc_accum.sv */
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: point accumulator
// Input register, running min/max/sum/count, and a snapshot on the last point.
// ----------------------------------------------------------------------------
module lsrc_accum #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lsrc_point_if.sink                       points,
	output logic                             job_valid,
	input  logic                             job_ready,
	output logic [lsrc_pkg::COORD_W-1:0]     job_span_x,
	output logic [lsrc_pkg::COORD_W-1:0]     job_span_y,
	output logic [$clog2(MAX_POINTS * ((1 << lsrc_pkg::COORD_W) - 1) + 1)-1:0] job_total_x,
	output logic [$clog2(MAX_POINTS * ((1 << lsrc_pkg::COORD_W) - 1) + 1)-1:0] job_total_y,
	output logic [$clog2(MAX_POINTS + 1)-1:0] job_count
);

	localparam int CW  = lsrc_pkg::COORD_W;
	localparam int N_W = $clog2(MAX_POINTS + 1);
	localparam int T_W = $clog2(MAX_POINTS * ((1 << CW) - 1) + 1);

	logic          valid_s1;
	logic [CW-1:0] x_s1;
	logic [CW-1:0] y_s1;
	logic          last_s1;
	logic          go_s1;

	logic [CW-1:0]  least_x_q, greatest_x_q, least_y_q, greatest_y_q;
	logic [T_W-1:0] total_x_q, total_y_q;
	logic [N_W-1:0] count_q;

	logic [CW-1:0]  least_x_n, greatest_x_n, least_y_n, greatest_y_n;
	logic [T_W-1:0] total_x_n, total_y_n;
	logic [N_W-1:0] count_n;
	logic           keep;

	logic           job_valid_s2;
	logic [CW-1:0]  span_x_s2, span_y_s2;
	logic [T_W-1:0] total_x_s2, total_y_s2;
	logic [N_W-1:0] count_s2;

	// a non-last point never waits; a last point waits for a free snapshot slot
	assign go_s1        = valid_s1 && (!last_s1 || !job_valid_s2 || job_ready);
	assign points.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (points.ready) begin
			valid_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (points.ready && points.valid) begin
			x_s1    <= points.point_x;
			y_s1    <= points.point_y;
			last_s1 <= points.last_point;
		end
	end

	// drop points beyond the capacity
	assign keep = count_q < N_W'(MAX_POINTS);

	always_comb begin
		least_x_n    = least_x_q;
		greatest_x_n = greatest_x_q;
		least_y_n    = least_y_q;
		greatest_y_n = greatest_y_q;
		total_x_n    = total_x_q;
		total_y_n    = total_y_q;
		count_n      = count_q;
		if (keep) begin
			if (x_s1 < least_x_q)    least_x_n    = x_s1;
			if (x_s1 > greatest_x_q) greatest_x_n = x_s1;
			if (y_s1 < least_y_q)    least_y_n    = y_s1;
			if (y_s1 > greatest_y_q) greatest_y_n = y_s1;
			total_x_n = total_x_q + T_W'(x_s1);
			total_y_n = total_y_q + T_W'(y_s1);
			count_n   = count_q + N_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_x_q    <= '1;
			greatest_x_q <= '0;
			least_y_q    <= '1;
			greatest_y_q <= '0;
			total_x_q    <= '0;
			total_y_q    <= '0;
			count_q      <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				least_x_q    <= '1;
				greatest_x_q <= '0;
				least_y_q    <= '1;
				greatest_y_q <= '0;
				total_x_q    <= '0;
				total_y_q    <= '0;
				count_q      <= '0;
			end else begin
				least_x_q    <= least_x_n;
				greatest_x_q <= greatest_x_n;
				least_y_q    <= least_y_n;
				greatest_y_q <= greatest_y_n;
				total_x_q    <= total_x_n;
				total_y_q    <= total_y_n;
				count_q      <= count_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s2 <= 1'b0;
		end else if (go_s1 && last_s1) begin
			job_valid_s2 <= 1'b1;
		end else if (job_ready) begin
			job_valid_s2 <= 1'b0;
		end
	end

	// at least one point is always kept, so greatest never lies below least
	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			span_x_s2  <= greatest_x_n - least_x_n;
			span_y_s2  <= greatest_y_n - least_y_n;
			total_x_s2 <= total_x_n;
			total_y_s2 <= total_y_n;
			count_s2   <= count_n;
		end
	end

	assign job_valid   = job_valid_s2;
	assign job_span_x  = span_x_s2;
	assign job_span_y  = span_y_s2;
	assign job_total_x = total_x_s2;
	assign job_total_y = total_y_s2;
	assign job_count   = count_s2;

endmodule

/* rtl/core/lsrc_verdict.sv */
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: verdict pipeline
// Products stage, then comparisons and fail priority into the result register.
// ----------------------------------------------------------------------------
module lsrc_verdict #(
	parameter int MAX_POINTS = lsrc_pkg::DEF_MAX_POINTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lsrc_pkg::rect_t                  rect,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  logic [lsrc_pkg::COORD_W-1:0]     job_span_x,
	input  logic [lsrc_pkg::COORD_W-1:0]     job_span_y,
	input  logic [$clog2(MAX_POINTS * ((1 << lsrc_pkg::COORD_W) - 1) + 1)-1:0] job_total_x,
	input  logic [$clog2(MAX_POINTS * ((1 << lsrc_pkg::COORD_W) - 1) + 1)-1:0] job_total_y,
	input  logic [$clog2(MAX_POINTS + 1)-1:0] job_count,
	lsrc_result_if.source                    verdict
);

	localparam int RW    = lsrc_pkg::RECT_W;
	localparam int CW    = lsrc_pkg::COORD_W;
	localparam int N_W   = $clog2(MAX_POINTS + 1);
	localparam int T_W   = $clog2(MAX_POINTS * ((1 << CW) - 1) + 1);
	localparam int SP_W  = RW + 5;          // 24 * size
	localparam int BS_W  = RW + 6;          // 32 * edge + 16 * size
	localparam int L_W   = T_W + 1;         // 2 * total
	localparam int P_W   = N_W + BS_W;      // count * centre term
	localparam int B_W   = N_W + RW;        // count * size
	localparam int M1_W  = (L_W > P_W) ? L_W : P_W;
	localparam int CMP_W = (M1_W > (B_W + 4)) ? M1_W : (B_W + 4);

	logic [SP_W-1:0] lim_x, lim_y;
	logic [BS_W-1:0] base_x, base_y;

	logic           valid_s3;
	logic           span_x_fail_s3, span_y_fail_s3;
	logic [L_W-1:0] lhs_x_s3, lhs_y_s3;
	logic [P_W-1:0] ctr_x_s3, ctr_y_s3;
	logic [B_W-1:0] bnd_x_s3, bnd_y_s3;

	logic           valid_s4;
	logic           inside_s4;
	logic [lsrc_pkg::REASON_W-1:0] reason_s4;

	logic             out_free, s3_free;
	logic [CMP_W-1:0] lx, cx, ly, cy, dist_x, dist_y, lim_cx, lim_cy;
	logic             ctr_x_fail, ctr_y_fail;
	lsrc_pkg::reason_t reason;

	assign out_free  = !valid_s4 || verdict.ready;
	assign s3_free   = !valid_s3 || out_free;
	assign job_ready = s3_free;

	// span limits and centre terms in 1/16 pixel units
	assign lim_x  = SP_W'({rect.width, 4'b0}) + SP_W'({rect.width, 3'b0});
	assign lim_y  = SP_W'({rect.height, 4'b0}) + SP_W'({rect.height, 3'b0});
	assign base_x = BS_W'({rect.left, 5'b0}) + BS_W'({rect.width, 4'b0});
	assign base_y = BS_W'({rect.top, 5'b0}) + BS_W'({rect.height, 4'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= job_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && job_valid) begin
			span_x_fail_s3 <= SP_W'(job_span_x) > lim_x;
			span_y_fail_s3 <= SP_W'(job_span_y) > lim_y;
			lhs_x_s3       <= {job_total_x, 1'b0};
			lhs_y_s3       <= {job_total_y, 1'b0};
			ctr_x_s3       <= {{BS_W{1'b0}}, job_count} * {{N_W{1'b0}}, base_x};
			ctr_y_s3       <= {{BS_W{1'b0}}, job_count} * {{N_W{1'b0}}, base_y};
			bnd_x_s3       <= {{RW{1'b0}}, job_count} * {{N_W{1'b0}}, rect.width};
			bnd_y_s3       <= {{RW{1'b0}}, job_count} * {{N_W{1'b0}}, rect.height};
		end
	end

	// distance of twice the total from count times twice the centre
	always_comb begin
		lx     = CMP_W'(lhs_x_s3);
		cx     = CMP_W'(ctr_x_s3);
		ly     = CMP_W'(lhs_y_s3);
		cy     = CMP_W'(ctr_y_s3);
		dist_x = (lx >= cx) ? (lx - cx) : (cx - lx);
		dist_y = (ly >= cy) ? (ly - cy) : (cy - ly);
		lim_cx = CMP_W'({bnd_x_s3, 4'b0});
		lim_cy = CMP_W'({bnd_y_s3, 4'b0});
		ctr_x_fail = dist_x > lim_cx;
		ctr_y_fail = dist_y > lim_cy;
	end

	always_comb begin
		priority if (span_x_fail_s3) reason = lsrc_pkg::REASON_SPAN_X;
		else if (span_y_fail_s3)     reason = lsrc_pkg::REASON_SPAN_Y;
		else if (ctr_x_fail)         reason = lsrc_pkg::REASON_CTR_X;
		else if (ctr_y_fail)         reason = lsrc_pkg::REASON_CTR_Y;
		else                         reason = lsrc_pkg::REASON_PASS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (out_free) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			inside_s4 <= (reason == lsrc_pkg::REASON_PASS);
			reason_s4 <= reason;
		end
	end

	assign verdict.valid       = valid_s4;
	assign verdict.inside_res  = inside_s4;
	assign verdict.fail_reason = reason_s4;

endmodule

/* sim/landmark_shape_in_rect_check_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark shape-in-rectangle check: testbench
// Streams landmark shapes into the block under randomised gaps and verdict
// back-pressure, predicts every verdict from its own copy of the rectangle
// and the accumulators, and compares each verdict transaction field by field.
// ----------------------------------------------------------------------------
module landmark_shape_in_rect_check_test;

	localparam int unsigned TARGET_POINTS = 1050;  // stop feeding shapes past this
	localparam int unsigned DRAIN_CYCLES  = 8;     // four-stage pipe plus margin
	localparam int unsigned STALL_LIMIT   = 2000;  // idle cycles before giving up
	localparam int unsigned REPORT_LIMIT  = 10;

	// how the points of one shape scatter around the configured rectangle
	typedef enum int {
		SPREAD_NOISE,
		SPREAD_INSIDE,
		SPREAD_LOOSE
	} spread_t;

	typedef struct packed {
		logic              fits;
		lsrc_pkg::reason_t reason;
	} fit_verdict_t;

	// ------------------------------------------------------------------------
	// Verdict scoreboard: mirrors the rectangle registers and the shape
	// accumulators, and queues the verdict each last point should produce.
	// ------------------------------------------------------------------------
	class shape_fit_board;
		lsrc_pkg::rect_t              rect;
		logic [lsrc_pkg::COORD_W-1:0] least_x, greatest_x, least_y, greatest_y;
		logic [22:0]                  total_x, total_y;
		logic [7:0]                   point_count;
		fit_verdict_t                 verdicts_due[$];
		int unsigned                  mismatches;

		function new();
			rect = '{left: '0, top: '0, width: 12'd1, height: 12'd1};
			mismatches = 0;
			clear_shape();
		endfunction

		function void clear_shape();
			least_x     = '1;
			least_y     = '1;
			greatest_x  = '0;
			greatest_y  = '0;
			total_x     = '0;
			total_y     = '0;
			point_count = '0;
		endfunction

		function void set_register(logic [lsrc_pkg::CFG_IDX_W-1:0] idx,
				logic [lsrc_pkg::RECT_W-1:0] data);
			case (lsrc_pkg::cfg_idx_t'(idx))
				lsrc_pkg::CFG_RECT_LEFT:   rect.left   = data;
				lsrc_pkg::CFG_RECT_TOP:    rect.top    = data;
				lsrc_pkg::CFG_RECT_WIDTH:  rect.width  = data;
				lsrc_pkg::CFG_RECT_HEIGHT: rect.height = data;
				default: ;  // unmapped index: the block drops the write
			endcase
		endfunction

		// doubled mean against doubled centre, all scaled by the point count
		function bit centre_strays(longint total, longint n, longint origin, longint size);
			longint offset;
			offset = 2 * total - n * (32 * origin + 16 * size);
			if (offset < 0)
				offset = -offset;
			return offset > 16 * n * size;
		endfunction

		function void note_point(logic [lsrc_pkg::COORD_W-1:0] x,
				logic [lsrc_pkg::COORD_W-1:0] y, logic last);
			lsrc_pkg::reason_t reason;
			fit_verdict_t      due;
			// once the shape is full, extra points are dropped
			if (point_count < lsrc_pkg::DEF_MAX_POINTS) begin
				if (x < least_x) least_x = x;
				if (x > greatest_x) greatest_x = x;
				if (y < least_y) least_y = y;
				if (y > greatest_y) greatest_y = y;
				total_x += x;
				total_y += y;
				point_count++;
			end
			if (!last)
				return;
			if (int'(greatest_x) - int'(least_x) > 24 * int'(rect.width))
				reason = lsrc_pkg::REASON_SPAN_X;
			else if (int'(greatest_y) - int'(least_y) > 24 * int'(rect.height))
				reason = lsrc_pkg::REASON_SPAN_Y;
			else if (centre_strays(total_x, point_count, rect.left, rect.width))
				reason = lsrc_pkg::REASON_CTR_X;
			else if (centre_strays(total_y, point_count, rect.top, rect.height))
				reason = lsrc_pkg::REASON_CTR_Y;
			else
				reason = lsrc_pkg::REASON_PASS;
			due.fits   = (reason == lsrc_pkg::REASON_PASS);
			due.reason = reason;
			verdicts_due = {verdicts_due, due};
			clear_shape();
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		function void check_verdict(logic fits, logic [lsrc_pkg::REASON_W-1:0] reason);
			fit_verdict_t due;
			if (verdicts_due.size() == 0) begin
				flag($sformatf("verdict inside=%0b reason=%0d with none outstanding",
					fits, reason));
				return;
			end
			due = verdicts_due.pop_front();
			if (fits !== due.fits || reason !== due.reason)
				flag($sformatf("verdict expected inside=%0b reason=%s, got inside=%0b reason=%0d",
					due.fits, due.reason.name(), fits, reason));
		endfunction

		function int unsigned waiting();
			return verdicts_due.size();
		endfunction

		function void flag_leftover();
			fit_verdict_t due;
			while (verdicts_due.size() != 0) begin
				due = verdicts_due.pop_front();
				flag($sformatf("verdict reason=%s never arrived", due.reason.name()));
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always #6 clk = ~clk;

	lsrc_point_if  points_ch ();
	lsrc_result_if verdict_ch ();
	lsrc_cfg_if    cfg_ch ();

	landmark_shape_in_rect_check #(
		.MAX_POINTS (lsrc_pkg::DEF_MAX_POINTS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.points  (points_ch),
		.verdict (verdict_ch),
		.cfg     (cfg_ch)
	);

	shape_fit_board board = new();

	int unsigned points_sent  = 0;
	int unsigned idle_cycles  = 0;
	bit          sender_calm  = 1'b0;
	bit          reader_calm  = 1'b0;

	// ------------------------------------------------------------------------
	// Watchdog: any transaction on any channel counts as progress
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((points_ch.valid && points_ch.ready) || (verdict_ch.valid && verdict_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Verdict side: draw a stall before each transaction, now and then switch
	// into a calm stretch where ready stays high throughout
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall;
		verdict_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				reader_calm = !reader_calm;
			stall = reader_calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			verdict_ch.ready <= 1'b1;
			@(posedge clk);
			while (!verdict_ch.valid)
				@(posedge clk);
			board.check_verdict(verdict_ch.inside_res, verdict_ch.fail_reason);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Point side helpers; every task starts and ends on a falling edge
	// ------------------------------------------------------------------------
	task automatic send_point(input logic [lsrc_pkg::COORD_W-1:0] x,
			input logic [lsrc_pkg::COORD_W-1:0] y, input logic last);
		int unsigned gap;
		if ($urandom_range(0, 15) == 0)
			sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 10);
		// drop valid only for a real gap, so back-to-back points keep it high
		if (gap != 0) begin
			points_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		points_ch.valid      <= 1'b1;
		points_ch.point_x    <= x;
		points_ch.point_y    <= y;
		points_ch.last_point <= last;
		@(posedge clk);
		while (!points_ch.ready)
			@(posedge clk);
		board.note_point(x, y, last);
		points_sent++;
		@(negedge clk);
	endtask

	// hold the point side until every outstanding verdict has been seen
	task automatic settle_verdicts(input bit with_drain);
		points_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (board.waiting() != 0);
		if (with_drain)
			repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lsrc_pkg::CFG_IDX_W-1:0] idx,
			input logic [lsrc_pkg::RECT_W-1:0] data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.set_register(idx, data);
		@(negedge clk);
	endtask

	// program the whole rectangle, optionally preceded by a write to an
	// unmapped index that must leave everything untouched
	task automatic apply_rect(input lsrc_pkg::rect_t r, input bit with_stray);
		if (with_stray)
			write_reg(lsrc_pkg::CFG_IDX_W'($urandom_range(int'(lsrc_pkg::CFG_RECT_HEIGHT) + 1,
				(1 << lsrc_pkg::CFG_IDX_W) - 1)), lsrc_pkg::RECT_W'($urandom_range(0, 4095)));
		write_reg(lsrc_pkg::CFG_RECT_LEFT, r.left);
		write_reg(lsrc_pkg::CFG_RECT_TOP, r.top);
		write_reg(lsrc_pkg::CFG_RECT_WIDTH, r.width);
		write_reg(lsrc_pkg::CFG_RECT_HEIGHT, r.height);
		cfg_ch.valid <= 1'b0;
	endtask

	// bias the edges towards the register extremes, sizes mostly modest so
	// that shapes land near the rectangle
	function automatic lsrc_pkg::rect_t draw_rect();
		lsrc_pkg::rect_t r;
		case ($urandom_range(0, 5))
			0:       r.left = '0;
			1:       r.left = '1;
			default: r.left = lsrc_pkg::RECT_W'($urandom_range(0, 4095));
		endcase
		case ($urandom_range(0, 5))
			0:       r.top = '0;
			1:       r.top = '1;
			default: r.top = lsrc_pkg::RECT_W'($urandom_range(0, 4095));
		endcase
		case ($urandom_range(0, 7))
			0:       r.width = '0;
			1:       r.width = '1;
			default: r.width = lsrc_pkg::RECT_W'($urandom_range(1, 400));
		endcase
		case ($urandom_range(0, 7))
			0:       r.height = '0;
			1:       r.height = '1;
			default: r.height = lsrc_pkg::RECT_W'($urandom_range(1, 400));
		endcase
		return r;
	endfunction

	function automatic logic [lsrc_pkg::COORD_W-1:0] pick_coord(input spread_t spread,
			input int origin_px, input int size_px);
		int value;
		case (spread)
			SPREAD_INSIDE: value = origin_px * 16 + $urandom_range(0, size_px * 16);
			SPREAD_LOOSE:  value = origin_px * 16 - size_px * 6
				+ $urandom_range(0, size_px * 28);
			default:       return lsrc_pkg::COORD_W'($urandom_range(0, 65535));
		endcase
		if (value < 0)
			value = 0;
		if (value > 65535)
			value = 65535;
		return value[lsrc_pkg::COORD_W-1:0];
	endfunction

	task automatic send_shape(input spread_t spread, input int unsigned length);
		for (int unsigned i = 0; i < length; i++)
			send_point(pick_coord(spread, board.rect.left, board.rect.width),
				pick_coord(spread, board.rect.top, board.rect.height), i == length - 1);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		spread_t     spread;
		int unsigned length;
		int unsigned pick;

		arst_n = 1'b0;
		points_ch.valid      <= 1'b0;
		points_ch.point_x    <= '0;
		points_ch.point_y    <= '0;
		points_ch.last_point <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.reg_index     <= '0;
		cfg_ch.wr_data       <= '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset rectangle, one pixel square at the origin
		send_point(16'd8, 16'd8, 1'b1);          // mean dead on the centre
		send_point(16'd0, 16'd0, 1'b1);          // mean exactly half a size away
		send_point(16'hFFFF, 16'hFFFF, 1'b1);    // far corner, x centre fails
		send_point(16'd0, 16'd8, 1'b0);
		send_point(16'd32, 16'd8, 1'b1);         // x span just past the limit

		settle_verdicts(1'b1);
		apply_rect('{left: 12'd100, top: 12'd50, width: 12'd200, height: 12'd150}, 1'b1);
		send_point(16'd1600, 16'd800, 1'b0);
		send_point(16'd1600, 16'd4401, 1'b1);    // y span one step over
		send_point(16'd3200, 16'd3300, 1'b1);    // y mean too low in the frame
		send_point(16'd3200, 16'd2000, 1'b1);    // centred
		send_point(16'd800, 16'd2000, 1'b0);
		send_point(16'd5600, 16'd2000, 1'b1);    // x span exactly at the limit

		// zero-sized rectangle: only a point on the corner passes
		settle_verdicts(1'b1);
		apply_rect('{left: 12'd10, top: 12'd10, width: 12'd0, height: 12'd0}, 1'b0);
		send_point(16'd160, 16'd160, 1'b1);
		send_point(16'd161, 16'd160, 1'b1);
		send_point(16'd160, 16'd161, 1'b1);

		// register extremes
		settle_verdicts(1'b1);
		apply_rect('{left: '1, top: '1, width: '1, height: '1}, 1'b0);
		send_point(16'hFFFF, 16'hFFFF, 1'b1);
		send_point(16'd0, 16'd0, 1'b1);

		// random phases: reprogram while idle, then a run of shapes
		while (points_sent < TARGET_POINTS) begin
			settle_verdicts(1'b1);
			apply_rect(draw_rect(), $urandom_range(0, 2) == 0);
			repeat ($urandom_range(4, 14)) begin
				// occasionally starve the pipe mid-phase
				if ($urandom_range(0, 11) == 0)
					settle_verdicts(1'b0);
				pick = $urandom_range(0, 9);
				spread = (pick < 2) ? SPREAD_NOISE : (pick < 6) ? SPREAD_INSIDE : SPREAD_LOOSE;
				// now and then fill a shape to around capacity, so any excess points are dropped
				length = ($urandom_range(0, 39) == 0) ? $urandom_range(125, 140)
					: $urandom_range(1, 12);
				send_shape(spread, length);
			end
		end

		settle_verdicts(1'b1);
		board.flag_leftover();
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
